@@ sv/tmcw_pkg.sv @@
`timescale 1ns / 1ps

package tmcw_pkg;

  // Field widths of the request, response and configuration ports
  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int ROWF_W     = 5;
  localparam int ADDR_W     = 11;
  localparam int COLF_W     = 7;
  localparam int OFF_W      = 11;
  localparam int COLOR_W    = 8;
  localparam int CELL_W     = CHAR_W + COLOR_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT        = 2'd0,
    MODE_CLEAR_ALL  = 2'd1,
    MODE_CLEAR_FROM = 2'd2,
    MODE_READ       = 2'd3
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_ROW  = 1'b1;

  localparam logic [CHAR_W-1:0]  CH_NEWLINE      = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_BACKSPACE    = 8'd8;
  localparam logic [CHAR_W-1:0]  CH_BLANK        = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR     = 8'd10;
  localparam logic [ROWF_W-1:0]  RESET_CLEAR_ROW = 5'd5;
  localparam logic [CELL_W-1:0]  RESET_BLANK     = {RESET_COLOR, CH_BLANK};

endpackage

@@ sv/tmcw_if.sv @@
`timescale 1ns / 1ps

interface tmcw_req_if;
  import tmcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHAR_W-1:0] char_code;
  logic [ROWF_W-1:0] first_row;
  logic [ADDR_W-1:0] cell_address;

  modport source (output valid, mode, char_code, first_row, cell_address, input ready);
  modport sink   (input valid, mode, char_code, first_row, cell_address, output ready);
endinterface

interface tmcw_rsp_if;
  import tmcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [COLF_W-1:0] cursor_column;
  logic [ROWF_W-1:0] cursor_line;
  logic [OFF_W-1:0]  cursor_offset;
  logic [CELL_W-1:0] cell_value;
  logic              overflow_cleared;

  modport source (output valid, cursor_column, cursor_line, cursor_offset, cell_value,
                  overflow_cleared, input ready);
  modport sink   (input valid, cursor_column, cursor_line, cursor_offset, cell_value,
                  overflow_cleared, output ready);
endinterface

@@ sv/tmcw_ram.sv @@
`timescale 1ns / 1ps

module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/text_mode_console_writer_core.sv @@
`timescale 1ns / 1ps

// Character-cell screen writer. The screen lives in one single-port-write,
// registered-read cell memory of ROWS*COLUMNS 16-bit entries (character in the
// low byte, attribute in the high byte); the cursor sits in two registers.
// Per request: a put-character request (printable, newline, backspace) and a
// read of an address beyond the screen load their response straight from the
// idle state; a read of a valid cell passes through the read state because of
// the memory's registered read. Any clear (clear all, clear from a row, or the
// clear a put-character triggers when the cursor runs past the bottom row)
// sweeps from row r, the start row saturated to ROWS-1, to the end of the
// screen, writing one blank cell a cycle through the memory's single write
// port. After reset the block runs a clearing pass over all ROWS*COLUMNS
// cells, filling the memory with blanks in the reset attribute; no request is
// accepted until it ends, while configuration writes are taken at any time.
// One request is in work at a time; a finished response waits in an output
// register, and the next request of any kind is accepted only while that
// register is empty or in the cycle its response is taken.
module text_mode_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tmcw_req_if.sink                        req_i,
  tmcw_rsp_if.source                      rsp_o,
  input  logic                            cfg_we_i,
  input  logic [tmcw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tmcw_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tmcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  localparam logic [AW-1:0]        LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0]        COLS_A    = AW'(COLUMNS);
  localparam logic [COL_W:0]       COLS_X    = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W:0]       ROWS_X    = (ROW_W + 1)'(ROWS);
  localparam logic [ADDR_W+AW-1:0] CELLS_X   = (ADDR_W + AW)'(CELLS);

  // Sequencer states
  localparam logic [1:0] ST_INIT  = 2'd0;  // reset clearing pass
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;  // blanking sweep to the end of screen
  localparam logic [1:0] ST_READ  = 2'd3;  // wait on memory read data

  // Saturate a requested clear row to the last row
  function automatic logic [ROW_W-1:0] limit_row(input logic [ROWF_W-1:0] r);
    logic [7:0] rx;
    rx = {3'b000, r};
    if (rx >= 8'(ROWS)) begin
      return ROW_W'(ROWS - 1);
    end
    return rx[ROW_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] color_q;
  logic [ROWF_W-1:0]  clr_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q   <= RESET_COLOR;
      clr_row_q <= RESET_CLEAR_ROW;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TEXT_COLOR: color_q   <= cfg_wdata_i[COLOR_W-1:0];
        CFG_CLEAR_ROW:  clr_row_q <= cfg_wdata_i[ROWF_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     ptr_q, ptr_d;      // sweep pointer
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [CELL_W-1:0] val_q, val_d;      // value to report once a sweep ends
  logic              ovf_q, ovf_d;

  logic              rsp_valid_q;
  logic [COLF_W-1:0] rsp_col_q;
  logic [ROWF_W-1:0] rsp_row_q;
  logic [OFF_W-1:0]  rsp_off_q;
  logic [CELL_W-1:0] rsp_val_q;
  logic              rsp_ovf_q;

  logic req_acc;

  // Take a request only when idle and the response register is free or draining
  assign req_i.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign req_acc     = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------------------
  // Put-character step
  // ---------------------------------------------------------------------------
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [AW-1:0]     row_base;
  logic [CELL_W-1:0] entry;
  logic [CELL_W-1:0] blank;
  logic              p_we;
  logic [AW-1:0]     p_addr;
  logic [CELL_W-1:0] p_val;
  logic [COL_W-1:0]  p_col;
  logic [ROW_W:0]    p_row_x;
  logic              p_ovf;

  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign row_base = AW'(row_q) * COLS_A;
  assign entry    = {color_q, req_i.char_code};
  assign blank    = {color_q, CH_BLANK};

  always_comb begin
    p_we    = 1'b0;
    p_addr  = row_base + AW'(col_q);
    p_val   = '0;
    p_col   = col_q;
    p_row_x = {1'b0, row_q};
    if (req_i.char_code == CH_NEWLINE) begin
      p_col   = '0;
      p_row_x = row_inc;
    end else if (req_i.char_code == CH_BACKSPACE) begin
      // Step back and blank that cell; nothing happens at the left edge
      if (col_q != '0) begin
        p_col  = col_q - 1'b1;
        p_we   = 1'b1;
        p_addr = row_base + AW'(col_q) - 1'b1;
        p_val  = blank;
      end
    end else begin
      p_we  = 1'b1;
      p_val = entry;
      if (col_inc == COLS_X) begin
        p_col   = '0;
        p_row_x = row_inc;
      end else begin
        p_col = col_inc[COL_W-1:0];
      end
    end
    p_ovf = (p_row_x >= ROWS_X);
  end

  // ---------------------------------------------------------------------------
  // Clear start and read address
  // ---------------------------------------------------------------------------
  logic [ROWF_W-1:0]    clr_src;
  logic [ROW_W-1:0]     clr_row;
  logic [AW-1:0]        clr_start;
  logic [ADDR_W+AW-1:0] addr_x;
  logic                 rd_in_range;

  always_comb begin
    case (req_i.mode)
      MODE_CLEAR_ALL:  clr_src = '0;
      MODE_CLEAR_FROM: clr_src = req_i.first_row;
      default:         clr_src = clr_row_q;
    endcase
  end

  assign clr_row     = limit_row(clr_src);
  assign clr_start   = AW'(clr_row) * COLS_A;
  assign addr_x      = (ADDR_W + AW)'(req_i.cell_address);
  assign rd_in_range = (addr_x < CELLS_X);

  // ---------------------------------------------------------------------------
  // Sequencer and memory port
  // ---------------------------------------------------------------------------
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [CELL_W-1:0] mem_rdata;
  logic              load;
  logic [CELL_W-1:0] ld_val;
  logic              ld_ovf;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    col_d     = col_q;
    row_d     = row_q;
    val_d     = val_q;
    ovf_d     = ovf_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = blank;
    mem_re    = 1'b0;
    load      = 1'b0;
    ld_val    = val_q;
    ld_ovf    = ovf_q;

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_BLANK;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == LAST_CELL) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_acc) begin
          unique case (req_i.mode) inside
            MODE_PUT: begin
              mem_we    = p_we;
              mem_waddr = p_addr;
              mem_wdata = p_val;
              if (p_ovf) begin
                // Ran past the bottom: blank from the configured row down
                col_d   = '0;
                row_d   = clr_row;
                ptr_d   = clr_start;
                val_d   = p_val;
                ovf_d   = 1'b1;
                state_d = ST_CLEAR;
              end else begin
                col_d  = p_col;
                row_d  = p_row_x[ROW_W-1:0];
                load   = 1'b1;
                ld_val = p_val;
                ld_ovf = 1'b0;
              end
            end
            MODE_CLEAR_ALL, MODE_CLEAR_FROM: begin
              col_d   = '0;
              row_d   = clr_row;
              ptr_d   = clr_start;
              val_d   = '0;
              ovf_d   = 1'b0;
              state_d = ST_CLEAR;
            end
            MODE_READ: begin
              if (rd_in_range) begin
                mem_re  = 1'b1;
                state_d = ST_READ;
              end else begin
                load   = 1'b1;
                ld_val = '0;
                ld_ovf = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + 1'b1;
        if (ptr_q == LAST_CELL) begin
          ptr_d   = '0;
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        load    = 1'b1;
        ld_val  = mem_rdata;
        ld_ovf  = 1'b0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      ptr_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      col_q   <= col_d;
      row_q   <= row_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  tmcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (addr_x[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Response register
  // ---------------------------------------------------------------------------
  logic [AW-1:0]         out_off;
  logic [AW+OFF_W-1:0]   out_off_x;
  logic [COL_W+COLF_W-1:0] out_col_x;
  logic [ROW_W+ROWF_W-1:0] out_row_x;

  // Report the cursor as it stands after this request
  assign out_off   = AW'(row_d) * COLS_A + AW'(col_d);
  assign out_off_x = (AW + OFF_W)'(out_off);
  assign out_col_x = (COL_W + COLF_W)'(col_d);
  assign out_row_x = (ROW_W + ROWF_W)'(row_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_col_q <= out_col_x[COLF_W-1:0];
      rsp_row_q <= out_row_x[ROWF_W-1:0];
      rsp_off_q <= out_off_x[OFF_W-1:0];
      rsp_val_q <= ld_val;
      rsp_ovf_q <= ld_ovf;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.cursor_column    = rsp_col_q;
  assign rsp_o.cursor_line      = rsp_row_q;
  assign rsp_o.cursor_offset    = rsp_off_q;
  assign rsp_o.cell_value       = rsp_val_q;
  assign rsp_o.overflow_cleared = rsp_ovf_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cursor_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, row_q} < ROWS_X) && ({1'b0, col_q} < COLS_X))
    else $error("cursor outside the screen");

  a_sweep_no_stale_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR || state_q == ST_READ) |-> !rsp_valid_q)
    else $error("response pending while a request is still in work");

  a_sweep_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && $past(state_q) == ST_CLEAR) |-> ptr_q == $past(ptr_q) + 1'b1)
    else $error("clear sweep skipped or repeated a cell");

  a_read_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_IDLE && rsp_valid_q))
    else $error("cell read did not complete in one cycle");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> !mem_we)
    else $error("cell write issued with a cell read");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

// Checks the character-cell screen writer against a cycle-free model of its
// screen memory and cursor. Requests are sent in random bursts, responses are
// taken under a changing stall pattern, and every response is compared field
// by field with the oldest predicted cursor report.
module testbench;
  import tmcw_pkg::*;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELL_COUNT  = COLUMNS * ROWS;
  // Allow several times the length of a whole-screen clear, or of the clearing
  // pass after reset, without any handshake.
  localparam int STALL_LIMIT = 12000;

  typedef struct {
    mode_e             mode;
    logic [CHAR_W-1:0] char_code;
    logic [ROWF_W-1:0] first_row;
    logic [ADDR_W-1:0] cell_address;
  } console_req_t;

  typedef struct packed {
    logic [COLF_W-1:0] cursor_column;
    logic [ROWF_W-1:0] cursor_line;
    logic [OFF_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] cell_value;
    logic              overflow_cleared;
  } cursor_report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tmcw_req_if req_if ();
  tmcw_rsp_if rsp_if ();

  text_mode_console_writer_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Screen model: cell memory, cursor and the two configuration registers
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0]  screen_model [CELL_COUNT];
  int unsigned        cursor_col;
  int unsigned        cursor_row;
  logic [COLOR_W-1:0] color_reg;
  logic [ROWF_W-1:0]  clear_row_reg;

  cursor_report_t expected_reports [$];
  cursor_report_t oldest_report;
  int             mismatch_count = 0;
  int             idle_cycles    = 0;
  int             burst_left     = 0;

  // Blank from a row to the bottom in the current color and park the cursor
  // at the start of that row; rows past the bottom saturate to the last row.
  function automatic void blank_from_row(int unsigned start);
    int unsigned top_row;
    top_row = (start >= ROWS) ? ROWS - 1 : start;
    for (int unsigned i = top_row * COLUMNS; i < CELL_COUNT; i++) begin
      screen_model[i] = {color_reg, CH_BLANK};
    end
    cursor_col = 0;
    cursor_row = top_row;
  endfunction

  // Advance the model by one accepted request and return the report it owes.
  function automatic cursor_report_t next_cursor_report(console_req_t rq);
    cursor_report_t    rep;
    logic [CELL_W-1:0] value;
    logic              overflowed;
    int unsigned       offset;
    value      = '0;
    overflowed = 1'b0;
    case (rq.mode)
      MODE_PUT: begin
        if (rq.char_code == CH_NEWLINE) begin
          cursor_col = 0;
          cursor_row++;
        end else if (rq.char_code == CH_BACKSPACE) begin
          // Backspace at the left edge leaves screen and cursor alone
          if (cursor_col > 0) begin
            cursor_col--;
            value = {color_reg, CH_BLANK};
            screen_model[cursor_row * COLUMNS + cursor_col] = value;
          end
        end else begin
          value = {color_reg, rq.char_code};
          screen_model[cursor_row * COLUMNS + cursor_col] = value;
          cursor_col++;
        end
        if (cursor_col >= COLUMNS) begin
          cursor_col = 0;
          cursor_row++;
        end
        // Running off the bottom clears from the configured row, no scroll;
        // the reported cell stays the one just written
        if (cursor_row >= ROWS) begin
          blank_from_row(clear_row_reg);
          overflowed = 1'b1;
        end
      end
      MODE_CLEAR_ALL:  blank_from_row(0);
      MODE_CLEAR_FROM: blank_from_row(rq.first_row);
      default: begin
        if (rq.cell_address < CELL_COUNT) value = screen_model[rq.cell_address];
      end
    endcase
    offset               = cursor_row * COLUMNS + cursor_col;
    rep.cursor_column    = COLF_W'(cursor_col);
    rep.cursor_line      = ROWF_W'(cursor_row);
    rep.cursor_offset    = OFF_W'(offset);
    rep.cell_value       = value;
    rep.overflow_cleared = overflowed;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Response checker and watchdog
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d (0x%0h), got %0d (0x%0h)", field, want, want, got, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_reports.size() == 0) begin
        $error("response arrived with no request outstanding");
        mismatch_count++;
      end else begin
        oldest_report = expected_reports.pop_front();
        compare_field("cursor_column", oldest_report.cursor_column, rsp_if.cursor_column);
        compare_field("cursor_line", oldest_report.cursor_line, rsp_if.cursor_line);
        compare_field("cursor_offset", oldest_report.cursor_offset, rsp_if.cursor_offset);
        compare_field("cell_value", oldest_report.cell_value, rsp_if.cell_value);
        compare_field("overflow_cleared", oldest_report.overflow_cleared,
                      rsp_if.overflow_cleared);
      end
    end
  end

  // Count cycles without any handshake on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Response side: stall on a repeating 8-bit ready pattern that is redrawn for
  // each new window; a third of the windows never stall. Bit 0 is always set so
  // that ready is high at least once in each pass through the pattern.
  // ---------------------------------------------------------------------------
  initial begin : response_stalls
    logic [7:0] stall_pattern;
    int         window;
    int         phase;
    stall_pattern = 8'hFF;
    window        = 0;
    phase         = 0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (window == 0) begin
        window        = 50;
        stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      window--;
      rsp_if.ready = stall_pattern[phase];
      phase        = (phase + 1) % 8;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  function automatic console_req_t random_request(mode_e mode);
    console_req_t rq;
    rq.mode         = mode;
    rq.char_code    = 8'($urandom);
    rq.first_row    = 5'($urandom);
    rq.cell_address = 11'($urandom);
    return rq;
  endfunction

  // Drive one request at the falling edge and hold it until accepted. Bursts
  // of random length keep valid high back to back; between bursts drop valid
  // for a random gap, or skip the gap now and then.
  task automatic send_request(input console_req_t rq);
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        req_if.valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
    burst_left--;
    req_if.valid        = 1'b1;
    req_if.mode         = rq.mode;
    req_if.char_code    = rq.char_code;
    req_if.first_row    = rq.first_row;
    req_if.cell_address = rq.cell_address;
    do @(posedge clk_i); while (!req_if.ready);
    expected_reports.push_back(next_cursor_report(rq));
  endtask

  task automatic send_put(input logic [CHAR_W-1:0] ch);
    console_req_t rq;
    rq           = random_request(MODE_PUT);
    rq.char_code = ch;
    send_request(rq);
  endtask

  task automatic send_read(input int unsigned addr);
    console_req_t rq;
    rq              = random_request(MODE_READ);
    rq.cell_address = ADDR_W'(addr);
    send_request(rq);
  endtask

  task automatic send_clear_from(input int unsigned row);
    console_req_t rq;
    rq           = random_request(MODE_CLEAR_FROM);
    rq.first_row = ROWF_W'(row);
    send_request(rq);
  endtask

  // Drop valid, wait for every outstanding response, then let the block settle
  task automatic drain_requests(input int settle_cycles);
    @(negedge clk_i);
    req_if.valid = 1'b0;
    burst_left   = 0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (settle_cycles) @(posedge clk_i);
  endtask

  // Write one register only once the block has gone quiet
  task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    drain_requests(4);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    if (idx == CFG_TEXT_COLOR) begin
      color_reg = data;
    end else begin
      clear_row_reg = data[ROWF_W-1:0];
    end
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset contents, field extremes and every edge case of the put and clear
  // paths, all under the reset color and clear row.
  task automatic test_directed_cases();
    send_read(0);                   // reset blank at both ends of the screen
    send_read(CELL_COUNT - 1);
    send_read(2047);                // addresses beyond the screen read as zero
    send_read(CELL_COUNT);
    send_put(8'h41);
    send_put(8'hFF);
    send_put(8'h00);
    send_put(CH_BACKSPACE);         // blanks column 2
    send_read(2);
    send_read(1);
    send_put(CH_BACKSPACE);
    send_put(CH_BACKSPACE);
    send_put(CH_BACKSPACE);         // already at the left edge: no effect
    send_put(CH_NEWLINE);
    send_clear_from(31);            // saturates to the last row
    send_put(8'h7E);
    send_put(CH_NEWLINE);           // passes the bottom: clear from row 5
    send_read((ROWS - 1) * COLUMNS);
    send_clear_from(0);
    send_put(8'h5A);
    send_request(random_request(MODE_CLEAR_ALL));
    send_read(0);
  endtask

  // Random mix of all operations under several register settings, extremes
  // included; newlines and clears are frequent enough to reach the bottom row.
  task automatic test_random_traffic();
    logic [COLOR_W-1:0] colors [5];
    logic [ROWF_W-1:0]  rows [5];
    int unsigned        pick;
    int unsigned        here;
    colors = '{8'h00, 8'hFF, 8'h5A, 8'($urandom), 8'($urandom)};
    rows   = '{5'd0, 5'd24, 5'd31, 5'($urandom_range(25, 31)), 5'($urandom_range(0, 24))};
    foreach (colors[p]) begin
      write_config(CFG_TEXT_COLOR, colors[p]);
      write_config(CFG_CLEAR_ROW, {3'($urandom), rows[p]});
      repeat (90) begin
        pick = $urandom_range(0, 99);
        if (pick < 52) begin
          send_put(8'($urandom));
        end else if (pick < 64) begin
          send_put(CH_NEWLINE);
        end else if (pick < 74) begin
          send_put(CH_BACKSPACE);
        end else if (pick < 77) begin
          send_request(random_request(MODE_CLEAR_ALL));
        end else if (pick < 83) begin
          send_request(random_request(MODE_CLEAR_FROM));
        end else if (pick < 91) begin
          send_request(random_request(MODE_READ));
        end else begin
          // Read back something just written near the cursor
          here = cursor_row * COLUMNS + cursor_col;
          send_read((here > 3) ? here - $urandom_range(0, 3) : here);
        end
      end
    end
  endtask

  // Type a full line on the last row so a printable byte runs off the bottom,
  // then read the cell it wrote, under varying clear rows.
  task automatic test_bottom_overflow();
    logic [CHAR_W-1:0] ch;
    for (int k = 0; k < 4; k++) begin
      write_config(CFG_TEXT_COLOR, 8'($urandom));
      write_config(CFG_CLEAR_ROW, 8'($urandom_range(0, 31)));
      send_clear_from($urandom_range(ROWS - 1, 31));
      repeat (COLUMNS + $urandom_range(0, 12)) begin
        ch = 8'($urandom);
        if (ch == CH_NEWLINE || ch == CH_BACKSPACE) ch = ch ^ 8'h01;
        send_put(ch);
      end
      send_read(CELL_COUNT - 1);
      send_read(CELL_COUNT - COLUMNS + $urandom_range(0, COLUMNS - 1));
    end
  endtask

  initial begin
    req_if.valid        = 1'b0;
    req_if.mode         = MODE_PUT;
    req_if.char_code    = '0;
    req_if.first_row    = '0;
    req_if.cell_address = '0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_TEXT_COLOR;
    cfg_wdata           = '0;

    // Model state after reset: blank screen in the reset color, cursor home
    color_reg     = RESET_COLOR;
    clear_row_reg = RESET_CLEAR_ROW;
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = RESET_BLANK;
    cursor_col = 0;
    cursor_row = 0;

    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_traffic();
    test_bottom_overflow();

    drain_requests(16);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/tmcw_pkg.sv
sv/tmcw_if.sv
sv/tmcw_ram.sv
sv/text_mode_console_writer_core.sv
sim/testbench.sv
